FILE: rtl/core/cc10_pkg.sv
// ----------------------------------------------------------------------------
// cc10_pkg: shared types and constants for the 10-bit coefficient packer
// Holds the compression constants and the queue transaction type.
// ----------------------------------------------------------------------------
package cc10_pkg;

   localparam int unsigned COEFF_W     = 13;
   localparam int unsigned WIDE_W      = 16;
   localparam int unsigned COMP_W      = 10;
   localparam int unsigned NUMER_W     = 27;
   localparam int unsigned RECIP_W     = 21;
   localparam int unsigned RECIP_SHIFT = 32;
   localparam int unsigned PROD_W      = NUMER_W + RECIP_W;
   localparam int unsigned REM_W       = 13;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned RES_W       = 6;
   localparam int unsigned RES_CNT_W   = 3;

   localparam logic [WIDE_W-1:0]    MODULUS      = 16'd3329;
   localparam logic [NUMER_W-1:0]   HALF_MODULUS = 27'd1664;
   // floor(2^32 / 3329)
   localparam logic [RECIP_W-1:0]   RECIP        = 21'd1290167;
   localparam logic [REM_W-1:0]     MODULUS_LO   = 13'd3329;
   localparam logic [RES_CNT_W-1:0] FULL_COUNT   = 3'd6;
   localparam logic [RES_CNT_W-1:0] COUNT_STEP   = 3'd2;

   // one compressed coefficient waiting to be packed
   typedef struct packed {
      logic [COMP_W-1:0] value;
      logic              last;
   } item_type;

   // front pipeline occupancy
   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } front_status_type;

   // back end state, seen by the top level checks
   typedef struct packed {
      logic                 pend_valid;
      logic [RES_CNT_W-1:0] residual_count;
   } back_status_type;

endpackage

FILE: rtl/core/cc10_compress.sv
// ----------------------------------------------------------------------------
// cc10_compress: front end, coefficient compression pipeline
// Folds negative coefficients into range and divides by the modulus with a
// reciprocal multiply and a single correction step. Two register stages.
// ----------------------------------------------------------------------------
module cc10_compress (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [cc10_pkg::COEFF_W-1:0]   in_coefficient,
   input  logic                                  in_vector_end,
   output logic                                  out_push,
   output cc10_pkg::item_type                    out_item,
   output cc10_pkg::front_status_type            status
);

   logic [cc10_pkg::WIDE_W-1:0]  wide;
   logic [cc10_pkg::WIDE_W-1:0]  folded;
   logic [cc10_pkg::NUMER_W-1:0] numer;
   logic [cc10_pkg::PROD_W-1:0]  product;
   logic [cc10_pkg::REM_W-1:0]   remainder;

   logic                           s1_valid_ff, s1_valid_in;
   logic [cc10_pkg::NUMER_W-1:0]   s1_numer_ff;
   logic                           s1_last_ff;
   logic                           s2_valid_ff, s2_valid_in;
   logic [cc10_pkg::REM_W-1:0]     s2_quot_ff;
   logic [cc10_pkg::REM_W-1:0]     s2_numer_lo_ff;
   logic                           s2_last_ff;

   // sign extend to 16 bits, add the modulus to negatives with 16-bit wrap
   assign wide   = {{(cc10_pkg::WIDE_W-cc10_pkg::COEFF_W){in_coefficient[cc10_pkg::COEFF_W-1]}},
                    in_coefficient};
   assign folded = wide[cc10_pkg::WIDE_W-1] ? wide + cc10_pkg::MODULUS : wide;
   assign numer  = {1'b0, folded, {cc10_pkg::COMP_W{1'b0}}} + cc10_pkg::HALF_MODULUS;

   // estimate is the true quotient or one below it
   assign product = cc10_pkg::PROD_W'(s1_numer_ff) * cc10_pkg::PROD_W'(cc10_pkg::RECIP);

   // remainder stays below twice the modulus, so 13 low bits suffice
   assign remainder = s2_numer_lo_ff - cc10_pkg::REM_W'(s2_quot_ff * cc10_pkg::MODULUS_LO);

   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (in_valid) begin
         s1_numer_ff <= numer;
         s1_last_ff  <= in_vector_end;
      end
      if (s1_valid_ff) begin
         s2_quot_ff     <= product[cc10_pkg::RECIP_SHIFT +: cc10_pkg::REM_W];
         s2_numer_lo_ff <= s1_numer_ff[cc10_pkg::REM_W-1:0];
         s2_last_ff     <= s1_last_ff;
      end
   end

   assign out_push       = s2_valid_ff;
   assign out_item.value = s2_quot_ff[cc10_pkg::COMP_W-1:0]
                         + cc10_pkg::COMP_W'(remainder >= cc10_pkg::MODULUS_LO);
   assign out_item.last  = s2_last_ff;

   assign status.s1_valid = s1_valid_ff;
   assign status.s2_valid = s2_valid_ff;

endmodule

FILE: rtl/core/cc10_fifo.sv
// ----------------------------------------------------------------------------
// cc10_fifo: short queue between compression front end and packer
// Circular buffer with occupancy count; writes are credited by the top level.
// ----------------------------------------------------------------------------
module cc10_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  cc10_pkg::item_type             push_item,
   input  logic                           pop,
   output logic                           pop_valid,
   output cc10_pkg::item_type             pop_item,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   cc10_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

FILE: rtl/core/cc10_packer.sv
// ----------------------------------------------------------------------------
// cc10_packer: back end, little-endian bit packer
// Merges each 10-bit value with the carried bits and emits one byte a cycle
// unless stalled, via an output register, holding a second byte when ready.
// ----------------------------------------------------------------------------
module cc10_packer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 item_valid,
   input  cc10_pkg::item_type                   item,
   output logic                                 item_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cc10_pkg::BYTE_W-1:0]          rsp_packed_byte,
   output logic                                 rsp_byte_last,
   output cc10_pkg::back_status_type            status
);

   localparam int ACC_W = 2 * cc10_pkg::BYTE_W;

   logic                              load;
   logic                              two_bytes;
   logic [ACC_W-1:0]                  acc;

   logic                              out_valid_ff;
   logic [cc10_pkg::BYTE_W-1:0]       out_byte_ff;
   logic                              out_last_ff;
   logic                              pend_valid_ff;
   logic [cc10_pkg::BYTE_W-1:0]       pend_byte_ff;
   logic                              pend_last_ff;
   logic [cc10_pkg::RES_W-1:0]        residual_bits_ff;
   logic [cc10_pkg::RES_CNT_W-1:0]    residual_count_ff;

   assign load      = !out_valid_ff || !rsp_stall;
   assign item_pop  = load && !pend_valid_ff && item_valid;
   assign two_bytes = item.last || (residual_count_ff == cc10_pkg::FULL_COUNT);

   // bits above count plus ten stay zero, which gives the zero padding on flush
   assign acc = (ACC_W'(item.value) << residual_count_ff) | ACC_W'(residual_bits_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff      <= 1'b0;
         pend_valid_ff     <= 1'b0;
         residual_bits_ff  <= '0;
         residual_count_ff <= '0;
      end else if (load) begin
         if (pend_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_byte_ff   <= pend_byte_ff;
            out_last_ff   <= pend_last_ff;
            pend_valid_ff <= 1'b0;
         end else if (item_valid) begin
            out_valid_ff  <= 1'b1;
            out_byte_ff   <= acc[cc10_pkg::BYTE_W-1:0];
            out_last_ff   <= 1'b0;
            pend_valid_ff <= two_bytes;
            pend_byte_ff  <= acc[ACC_W-1:cc10_pkg::BYTE_W];
            pend_last_ff  <= item.last;
            if (two_bytes) begin
               residual_bits_ff  <= '0;
               residual_count_ff <= '0;
            end else begin
               residual_bits_ff  <= acc[cc10_pkg::BYTE_W +: cc10_pkg::RES_W];
               residual_count_ff <= residual_count_ff + cc10_pkg::COUNT_STEP;
            end
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_packed_byte = out_byte_ff;
   assign rsp_byte_last   = out_last_ff;

   assign status.pend_valid     = pend_valid_ff;
   assign status.residual_count = residual_count_ff;

endmodule

FILE: rtl/core/coeff_compress_10bit_packer.sv
// ----------------------------------------------------------------------------
// coeff_compress_10bit_packer: 10-bit coefficient compressor and byte packer
// Compresses signed coefficients to 10 bits and streams them as packed bytes.
// ----------------------------------------------------------------------------
// A coefficient can be accepted every cycle while the queue has room; the
// front end compresses it in a two-stage pipeline (reciprocal multiply, then
// a remainder correction) and queues the 10-bit value. The packer emits one
// byte per cycle through its output register while rsp_stall is low, so
// the sustained rate is set by the byte port: five bytes per four
// coefficients within a vector, and always two bytes for the coefficient
// that ends a vector, the second one marked last. The first byte of a
// coefficient passes through both front-end stages, the queue and the
// packer output register before it shows on rsp_valid.
// QUEUE_DEPTH sets how many coefficients may be in flight between the input
// and the packer; req_stall rises when that many are held.
// ----------------------------------------------------------------------------
module coeff_compress_10bit_packer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [cc10_pkg::COEFF_W-1:0]  req_coefficient,
   input  logic                                 req_vector_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cc10_pkg::BYTE_W-1:0]          rsp_packed_byte,
   output logic                                 rsp_byte_last
);

   localparam int CW = $clog2(QUEUE_DEPTH+1);

   logic                            req_accept;
   logic                            push;
   cc10_pkg::item_type              push_item;
   logic                            pop;
   logic                            pop_valid;
   cc10_pkg::item_type              pop_item;
   logic [CW-1:0]                   fifo_count;
   logic [CW:0]                     occupancy;
   cc10_pkg::front_status_type      front_status;
   cc10_pkg::back_status_type       back_status;

   // count items still in the pipeline against the queue space
   assign occupancy  = {1'b0, fifo_count} + (CW+1)'(front_status.s1_valid)
                     + (CW+1)'(front_status.s2_valid);
   assign req_stall  = (occupancy >= (CW+1)'(QUEUE_DEPTH));
   assign req_accept = req_valid && !req_stall;

   cc10_compress u_compress (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_accept),
      .in_coefficient (req_coefficient),
      .in_vector_end  (req_vector_end),
      .out_push       (push),
      .out_item       (push_item),
      .status         (front_status)
   );

   cc10_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .count     (fifo_count)
   );

   cc10_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (pop_valid),
      .item            (pop_item),
      .item_pop        (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_byte_last   (rsp_byte_last),
      .status          (back_status)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_count != CW'(QUEUE_DEPTH)))
      else $error("queue written while full");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= (CW+1)'(QUEUE_DEPTH))
      else $error("more items in flight than queue space");

   a_residual_even: assert property (@(posedge clock) disable iff (reset)
      (back_status.residual_count == 3'd0) || (back_status.residual_count == 3'd2) ||
      (back_status.residual_count == 3'd4) || (back_status.residual_count == 3'd6))
      else $error("carried bit count out of step");

   a_pend_behind_output: assert property (@(posedge clock) disable iff (reset)
      back_status.pend_valid |-> rsp_valid)
      else $error("held byte without a byte on the output");

endmodule

FILE: test/coeff_compress_10bit_packer_test.sv
// ----------------------------------------------------------------------------
// coeff_compress_10bit_packer_test: self-checking bench for the du10 packer
// Drives signed coefficients with end-of-vector marks, predicts the packed
// byte stream with an in-bench model of the compressor and bit packer, and
// checks every output byte in order under varied sender and receiver idling.
// ----------------------------------------------------------------------------
module coeff_compress_10bit_packer_test;

   localparam int unsigned MOD_Q     = 3329;
   localparam int unsigned HALF_Q    = 1664;
   localparam int unsigned COMP_BITS = 10;
   localparam int          MAX_SHOWN = 10;
   localparam int          DRAIN_CAP = 100000;

   typedef struct packed {
      logic [cc10_pkg::BYTE_W-1:0] data;
      logic                        last;
   } stream_byte_type;

   logic                                clock           = 1'b0;
   logic                                reset           = 1'b1;
   logic                                req_valid       = 1'b0;
   logic                                req_stall;
   logic signed [cc10_pkg::COEFF_W-1:0] req_coefficient = '0;
   logic                                req_vector_end  = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall       = 1'b0;
   logic [cc10_pkg::BYTE_W-1:0]         rsp_packed_byte;
   logic                                rsp_byte_last;

   // packer model state
   logic [5:0]      carry_bits  = '0;
   int unsigned     carry_count = 0;
   stream_byte_type pending_bytes[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_cycles   = 0;

   coeff_compress_10bit_packer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_coefficient (req_coefficient),
      .req_vector_end  (req_vector_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_byte_last   (rsp_byte_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #400000;
      $display("coeff_compress_10bit_packer_test: done, errors");
      $finish;
   end

   function automatic logic [COMP_BITS-1:0] compress10(input logic signed [12:0] coeff);
      logic [15:0] wide;
      logic [31:0] numer;
      wide = {{3{coeff[12]}}, coeff};
      if (wide[15]) begin
         wide = wide + 16'(MOD_Q);
      end
      numer = ({16'd0, wide} << COMP_BITS) + 32'(HALF_Q);
      return COMP_BITS'(numer / 32'(MOD_Q));
   endfunction

   // append the bytes one accepted coefficient completes
   task automatic predict_bytes(input logic signed [12:0] coeff, input logic vend);
      logic [15:0]     acc;
      int unsigned     total;
      int              count;
      stream_byte_type out_bytes[2];
      acc   = 16'(carry_bits) | (16'(compress10(coeff)) << carry_count);
      total = carry_count + COMP_BITS;
      count = 0;
      while (total >= 8 && count < 2) begin
         out_bytes[count] = '{data: acc[7:0], last: 1'b0};
         acc   = acc >> 8;
         total = total - 8;
         count++;
      end
      if (vend) begin
         // flush the partial byte, zero padded
         if (total > 0 && count < 2) begin
            out_bytes[count] = '{data: acc[7:0] & 8'((1 << total) - 1), last: 1'b0};
            count++;
         end
         if (count > 0) begin
            out_bytes[count-1].last = 1'b1;
         end
         carry_bits  = '0;
         carry_count = 0;
      end else begin
         carry_bits  = acc[5:0] & 6'((1 << total) - 1);
         carry_count = total;
      end
      for (int i = 0; i < count; i++) begin
         pending_bytes.push_back(out_bytes[i]);
      end
   endtask

   task automatic send_coeff(input logic signed [12:0] coeff, input logic vend);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_coefficient <= coeff;
      req_vector_end  <= vend;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_bytes(coeff, vend);
   endtask

   // receiver: long hold-off when requested, else random stall
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      stream_byte_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
               $display("unexpected byte %02h last %b", rsp_packed_byte, rsp_byte_last);
            end
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_packed_byte !== want.data || rsp_byte_last !== want.last) begin
               error_count++;
               if (error_count <= MAX_SHOWN) begin
                  $display("byte mismatch: expected %02h last %b, got %02h last %b",
                           want.data, want.last, rsp_packed_byte, rsp_byte_last);
               end
            end
         end
      end
   end

   task automatic test_extreme_coefficients();
      int values[10];
      values = '{-3328, 3328, 0, -1, 1, 1664, -4096, 4095, 3329, -3329};
      for (int i = 0; i < 10; i++) begin
         send_coeff(13'(values[i]), i == 9);
      end
   endtask

   // end the vector with 0, 2, 4 and 6 bits carried
   task automatic test_flush_phases();
      for (int len = 1; len <= 4; len++) begin
         for (int i = 0; i < len; i++) begin
            send_coeff(13'($urandom_range(6656) - 3328), i == len - 1);
         end
      end
   endtask

   task automatic test_random_vectors(input int item_target);
      int sent;
      int len;
      int pick;
      int value;
      bit broken;
      sent = 0;
      while (sent < item_target) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            len = $urandom_range(12, 1);
         end else if (pick < 97) begin
            len = $urandom_range(64, 13);
         end else begin
            len = 256;
         end
         // occasionally run on into the next vector without an end mark
         broken = ($urandom_range(9) == 0);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
               value = $urandom_range(6656) - 3328;
            end else if (pick < 90) begin
               case ($urandom_range(3))
                  0: value = -3328;
                  1: value = 3328;
                  2: value = 0;
                  default: value = -1;
               endcase
            end else begin
               value = $urandom();
            end
            send_coeff(13'(value), (i == len - 1) && !broken);
            sent++;
         end
      end
      // close any open vector so no bits stay carried
      if (carry_count != 0) begin
         send_coeff(13'($urandom_range(6656) - 3328), 1'b1);
      end
   endtask

   // hold the output long enough that the block fills and stalls its input
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_cycles   = 200;
      test_random_vectors(40);
   endtask

   initial begin
      int waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 0;
      stall_pct     = 0;
      test_extreme_coefficients();
      test_flush_phases();

      test_random_vectors(300);
      send_idle_pct = 60;
      test_random_vectors(300);
      send_idle_pct = 0;
      stall_pct     = 60;
      test_random_vectors(300);
      send_idle_pct = 10;
      stall_pct     = 10;
      test_random_vectors(300);
      test_output_hold_off();

      req_valid <= 1'b0;
      stall_pct = 0;
      waited = 0;
      while ((pending_bytes.size() != 0 || hold_cycles != 0) && waited < DRAIN_CAP) begin
         @(posedge clock);
         waited++;
      end
      if (pending_bytes.size() != 0) begin
         error_count++;
         $display("%0d bytes never arrived", pending_bytes.size());
      end
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("coeff_compress_10bit_packer_test: done, clean");
      end else begin
         $display("coeff_compress_10bit_packer_test: done, errors");
      end
      $finish;
   end

endmodule

FILE: coeff_compress_10bit_packer.f
rtl/core/cc10_pkg.sv
rtl/core/cc10_compress.sv
rtl/core/cc10_fifo.sv
rtl/core/cc10_packer.sv
rtl/core/coeff_compress_10bit_packer.sv
test/coeff_compress_10bit_packer_test.sv
